// ===== hw/rtl/assert_macros.svh =====
// Assertion macros for the checker file of this block.
// Needs nothing else; every macro clocks on a rising edge and is off while reset is low.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Antecedent holds in this cycle, consequent holds in the same cycle.
`define EMH_ASSERT_SAME(label, clk, rst_n, ante, cons) \
	label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
		else $error("same-cycle property failed");

// Antecedent holds in this cycle, consequent holds in the next one.
`define EMH_ASSERT_NEXT(label, clk, rst_n, ante, cons) \
	label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
		else $error("next-cycle property failed");

`endif

// ===== hw/rtl/emh_pkg.sv =====
// Shared types and constants of the event multiplicity histogrammer.
// Used by every module of the block; depends on nothing.
package emh_pkg;

	localparam int CHAMBER_BINS_DEF = 1024;
	localparam int TOTAL_BINS_DEF   = 4096;
	localparam int COUNT_WIDTH_DEF  = 32;

	localparam logic CMD_RECORD = 1'b0;
	localparam logic CMD_READ   = 1'b1;

	// histogram select codes; also the order of the chamber banks
	localparam logic [2:0] SEL_HIT_TOP     = 3'd0;
	localparam logic [2:0] SEL_HIT_MIDDLE  = 3'd1;
	localparam logic [2:0] SEL_HIT_BOTTOM  = 3'd2;
	localparam logic [2:0] SEL_CLU_TOP     = 3'd3;
	localparam logic [2:0] SEL_CLU_MIDDLE  = 3'd4;
	localparam logic [2:0] SEL_CLU_BOTTOM  = 3'd5;
	localparam logic [2:0] SEL_HIT_TOTAL   = 3'd6;
	localparam logic [2:0] SEL_CLU_TOTAL   = 3'd7;

	localparam int NUM_CHAMBER_HISTS = 6;
	localparam int NUM_CATEGORIES    = 6;

	// category counter slots
	localparam int CAT_NO_HIT         = 0;
	localparam int CAT_FEW_HIT        = 1;
	localparam int CAT_MANY_HIT       = 2;
	localparam int CAT_SINGLE_CLUSTER = 3;
	localparam int CAT_DOUBLE_CLUSTER = 4;
	localparam int CAT_MANY_CLUSTER   = 5;

	typedef struct packed {
		logic        cmd;
		logic [9:0]  hits_top;
		logic [9:0]  hits_middle;
		logic [9:0]  hits_bottom;
		logic [9:0]  clusters_top;
		logic [9:0]  clusters_middle;
		logic [9:0]  clusters_bottom;
		logic [11:0] hits_total;
		logic [11:0] clusters_total;
		logic [2:0]  hist_select;
		logic [11:0] bin_index;
	} emh_item_t;

	typedef struct packed {
		logic [31:0] bin_count;
		logic [31:0] no_hit_events;
		logic [31:0] few_hit_events;
		logic [31:0] many_hit_events;
		logic [31:0] single_cluster_events;
		logic [31:0] double_cluster_events;
		logic [31:0] many_cluster_events;
	} emh_result_t;

	// controller to datapath
	typedef struct packed {
		logic accept;  // item taken: issue bank reads, latch item
		logic finish;  // write back bumps, update counters, load result
		logic clear;   // clearing pass, zero the swept address
	} emh_cmd_t;

endpackage

// ===== hw/rtl/emh_bank.sv =====
// One histogram memory with a registered read port and a saturating bump write-back.
// Depends on emh_pkg for the default sizes.
module emh_bank #(
	parameter int DEPTH = emh_pkg::CHAMBER_BINS_DEF,
	parameter int WIDTH = emh_pkg::COUNT_WIDTH_DEF,
	localparam int AW = $clog2(DEPTH)
) (
	input  logic             clk,
	input  logic             rd_en,
	input  logic [AW-1:0]    rd_addr,
	input  logic             bump_en,
	input  logic             clr_en,
	input  logic [AW-1:0]    clr_addr,
	output logic [WIDTH-1:0] rd_data
);
	import emh_pkg::*;

	logic [WIDTH-1:0] mem [DEPTH];
	logic [WIDTH-1:0] rd_q;
	logic [AW-1:0]    addr_q;
	logic             wr_en;
	logic [AW-1:0]    wr_addr;
	logic [WIDTH-1:0] wr_data;
	logic [WIDTH-1:0] bumped;

	// saturate at all ones
	assign bumped  = (rd_q == '1) ? rd_q : rd_q + 1'b1;
	assign wr_en   = clr_en | bump_en;
	assign wr_addr = clr_en ? clr_addr : addr_q;
	assign wr_data = clr_en ? '0 : bumped;
	assign rd_data = rd_q;

	always_ff @(posedge clk) begin
		if (rd_en) begin
			rd_q   <= mem[rd_addr];
			addr_q <= rd_addr;
		end
		if (wr_en) begin
			mem[wr_addr] <= wr_data;
		end
	end

endmodule

// ===== hw/rtl/emh_datapath.sv =====
// Datapath: eight histogram banks, category flags and counters, result register.
// Depends on emh_pkg and emh_bank; driven by emh_ctrl through emh_cmd_t.
module emh_datapath #(
	parameter int CHAMBER_BINS = emh_pkg::CHAMBER_BINS_DEF,
	parameter int TOTAL_BINS   = emh_pkg::TOTAL_BINS_DEF,
	parameter int COUNT_WIDTH  = emh_pkg::COUNT_WIDTH_DEF,
	parameter int SWEEP_DEPTH  = emh_pkg::TOTAL_BINS_DEF,
	localparam int SW = $clog2(SWEEP_DEPTH)
) (
	input  logic                clk,
	input  logic                arst_n,
	input  emh_pkg::emh_cmd_t   cmd,
	input  logic [SW-1:0]       sweep,
	input  emh_pkg::emh_item_t  item,
	output emh_pkg::emh_result_t result
);
	import emh_pkg::*;

	localparam int CAW = $clog2(CHAMBER_BINS);
	localparam int TAW = $clog2(TOTAL_BINS);

	function automatic logic [9:0] chamber_field(input emh_item_t it, input logic [2:0] k);
		case (k)
			SEL_HIT_TOP:    chamber_field = it.hits_top;
			SEL_HIT_MIDDLE: chamber_field = it.hits_middle;
			SEL_HIT_BOTTOM: chamber_field = it.hits_bottom;
			SEL_CLU_TOP:    chamber_field = it.clusters_top;
			SEL_CLU_MIDDLE: chamber_field = it.clusters_middle;
			SEL_CLU_BOTTOM: chamber_field = it.clusters_bottom;
			default:        chamber_field = '0;
		endcase
	endfunction

	emh_item_t        item_q;
	emh_result_t      res_q;
	emh_result_t      res_d;

	logic [CAW-1:0]   ch_addr [NUM_CHAMBER_HISTS];
	logic             ch_bump [NUM_CHAMBER_HISTS];
	logic [COUNT_WIDTH-1:0] ch_rd [NUM_CHAMBER_HISTS];
	logic [TAW-1:0]   tot_addr [2];
	logic             tot_bump [2];
	logic [COUNT_WIDTH-1:0] tot_rd [2];

	logic [31:0]      sweep_ext;
	logic             ch_clr;
	logic             tot_clr;
	logic             record_q;
	logic             cidx_ok;
	logic             tidx_ok;
	logic [COUNT_WIDTH-1:0] bin;

	logic [NUM_CATEGORIES-1:0] flag;
	logic [COUNT_WIDTH-1:0] cnt_q   [NUM_CATEGORIES];
	logic [COUNT_WIDTH-1:0] cnt_nxt [NUM_CATEGORIES];

	assign sweep_ext = 32'(sweep);
	assign ch_clr    = cmd.clear && (sweep_ext < 32'(CHAMBER_BINS));
	assign tot_clr   = cmd.clear && (sweep_ext < 32'(TOTAL_BINS));
	assign record_q  = (item_q.cmd == CMD_RECORD);

	// bank addresses come from the live beat; bump enables from the held item
	always_comb begin
		logic [31:0] ext;
		logic [9:0]  val;
		logic [11:0] tval;
		for (int k = 0; k < NUM_CHAMBER_HISTS; k++) begin
			val = (item.cmd == CMD_READ) ? item.bin_index[9:0] : chamber_field(item, 3'(k));
			ext = 32'(val);
			ch_addr[k] = ext[CAW-1:0];
			ch_bump[k] = cmd.finish && record_q &&
				(32'(chamber_field(item_q, 3'(k))) < 32'(CHAMBER_BINS));
		end
		for (int j = 0; j < 2; j++) begin
			tval = (item.cmd == CMD_READ) ? item.bin_index :
				((j == 0) ? item.hits_total : item.clusters_total);
			ext = 32'(tval);
			tot_addr[j] = ext[TAW-1:0];
			tval = (j == 0) ? item_q.hits_total : item_q.clusters_total;
			tot_bump[j] = cmd.finish && record_q && (32'(tval) < 32'(TOTAL_BINS));
		end
	end

	for (genvar g = 0; g < NUM_CHAMBER_HISTS; g++) begin : g_chamber
		emh_bank #(
			.DEPTH(CHAMBER_BINS),
			.WIDTH(COUNT_WIDTH)
		) u_bank (
			.clk      (clk),
			.rd_en    (cmd.accept),
			.rd_addr  (ch_addr[g]),
			.bump_en  (ch_bump[g]),
			.clr_en   (ch_clr),
			.clr_addr (sweep_ext[CAW-1:0]),
			.rd_data  (ch_rd[g])
		);
	end

	for (genvar g = 0; g < 2; g++) begin : g_total
		emh_bank #(
			.DEPTH(TOTAL_BINS),
			.WIDTH(COUNT_WIDTH)
		) u_bank (
			.clk      (clk),
			.rd_en    (cmd.accept),
			.rd_addr  (tot_addr[g]),
			.bump_en  (tot_bump[g]),
			.clr_en   (tot_clr),
			.clr_addr (sweep_ext[TAW-1:0]),
			.rd_data  (tot_rd[g])
		);
	end

	// read path: out-of-range bins read as zero
	assign cidx_ok = (32'(item_q.bin_index[9:0]) < 32'(CHAMBER_BINS));
	assign tidx_ok = (32'(item_q.bin_index) < 32'(TOTAL_BINS));

	always_comb begin
		bin = '0;
		case (item_q.hist_select)
			SEL_HIT_TOP:    bin = cidx_ok ? ch_rd[0] : '0;
			SEL_HIT_MIDDLE: bin = cidx_ok ? ch_rd[1] : '0;
			SEL_HIT_BOTTOM: bin = cidx_ok ? ch_rd[2] : '0;
			SEL_CLU_TOP:    bin = cidx_ok ? ch_rd[3] : '0;
			SEL_CLU_MIDDLE: bin = cidx_ok ? ch_rd[4] : '0;
			SEL_CLU_BOTTOM: bin = cidx_ok ? ch_rd[5] : '0;
			SEL_HIT_TOTAL:  bin = tidx_ok ? tot_rd[0] : '0;
			SEL_CLU_TOTAL:  bin = tidx_ok ? tot_rd[1] : '0;
			default:        bin = '0;
		endcase
	end

	// event classification
	always_comb begin
		logic [9:0] h0, h1, h2, c0, c1, c2;
		h0 = item_q.hits_top;
		h1 = item_q.hits_middle;
		h2 = item_q.hits_bottom;
		c0 = item_q.clusters_top;
		c1 = item_q.clusters_middle;
		c2 = item_q.clusters_bottom;
		flag[CAT_NO_HIT]   = (h0 == 10'd0) || (h1 == 10'd0) || (h2 == 10'd0);
		flag[CAT_FEW_HIT]  = (h0 == 10'd1 || h0 == 10'd2) && (h1 == 10'd1 || h1 == 10'd2) &&
			(h2 == 10'd1 || h2 == 10'd2);
		flag[CAT_MANY_HIT] = (h0 > 10'd2) || (h1 > 10'd2) || (h2 > 10'd2);
		flag[CAT_SINGLE_CLUSTER] = (c0 == 10'd1) && (c1 == 10'd1) && (c2 == 10'd1);
		flag[CAT_DOUBLE_CLUSTER] = (c0 == 10'd2) && (c1 == 10'd2) && (c2 == 10'd2);
		flag[CAT_MANY_CLUSTER]   = (c0 > 10'd2) || (c1 > 10'd2) || (c2 > 10'd2);
	end

	always_comb begin
		for (int k = 0; k < NUM_CATEGORIES; k++) begin
			cnt_nxt[k] = (record_q && flag[k] && cnt_q[k] != '1) ? cnt_q[k] + 1'b1 : cnt_q[k];
		end
	end

	always_comb begin
		res_d.bin_count             = record_q ? 32'd0 : 32'(bin);
		res_d.no_hit_events         = 32'(cnt_nxt[CAT_NO_HIT]);
		res_d.few_hit_events        = 32'(cnt_nxt[CAT_FEW_HIT]);
		res_d.many_hit_events       = 32'(cnt_nxt[CAT_MANY_HIT]);
		res_d.single_cluster_events = 32'(cnt_nxt[CAT_SINGLE_CLUSTER]);
		res_d.double_cluster_events = 32'(cnt_nxt[CAT_DOUBLE_CLUSTER]);
		res_d.many_cluster_events   = 32'(cnt_nxt[CAT_MANY_CLUSTER]);
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			for (int k = 0; k < NUM_CATEGORIES; k++) begin
				cnt_q[k] <= '0;
			end
		end else if (cmd.finish) begin
			for (int k = 0; k < NUM_CATEGORIES; k++) begin
				cnt_q[k] <= cnt_nxt[k];
			end
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.accept) begin
			item_q <= item;
		end
		if (cmd.finish) begin
			res_q <= res_d;
		end
	end

	assign result = res_q;

endmodule

// ===== hw/rtl/emh_ctrl.sv =====
// Controller: clearing pass after reset, item sequencing and the result valid flag.
// Depends on emh_pkg; commands emh_datapath through emh_cmd_t.
module emh_ctrl #(
	parameter int SWEEP_DEPTH = emh_pkg::TOTAL_BINS_DEF,
	localparam int SW = $clog2(SWEEP_DEPTH)
) (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              item_valid,
	output logic              item_stall,
	output logic              result_valid,
	input  logic              result_stall,
	output emh_pkg::emh_cmd_t cmd,
	output logic [SW-1:0]     sweep
);
	import emh_pkg::*;

	localparam logic [1:0] ST_CLEAR = 2'd0;
	localparam logic [1:0] ST_IDLE  = 2'd1;
	localparam logic [1:0] ST_EXEC  = 2'd2;

	logic [1:0]    state_q;
	logic [SW-1:0] sweep_q;
	logic          result_valid_q;
	logic          out_free;

	assign out_free   = !result_valid_q || !result_stall;
	assign item_stall = (state_q != ST_IDLE);

	assign cmd.accept = (state_q == ST_IDLE) && item_valid;
	assign cmd.finish = (state_q == ST_EXEC) && out_free;
	assign cmd.clear  = (state_q == ST_CLEAR);

	assign sweep        = sweep_q;
	assign result_valid = result_valid_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_CLEAR;
			sweep_q <= '0;
		end else begin
			case (state_q)
				ST_CLEAR: begin
					sweep_q <= sweep_q + 1'b1;
					if (sweep_q == SW'(SWEEP_DEPTH - 1)) begin
						state_q <= ST_IDLE;
					end
				end
				ST_IDLE: begin
					if (item_valid) begin
						state_q <= ST_EXEC;
					end
				end
				ST_EXEC: begin
					// bank read data is held until the result register frees up
					if (out_free) begin
						state_q <= ST_IDLE;
					end
				end
				default: begin
					state_q <= ST_IDLE;
				end
			endcase
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			result_valid_q <= 1'b0;
		end else if (cmd.finish) begin
			result_valid_q <= 1'b1;
		end else if (!result_stall) begin
			result_valid_q <= 1'b0;
		end
	end

endmodule

// ===== hw/rtl/event_multiplicity_histogrammer.sv =====
// Top level of the event multiplicity histogrammer: controller plus datapath.
// Depends on emh_pkg, emh_ctrl, emh_datapath (and emh_bank below it).
//
//   channel  | handshake                  | beat
//   ---------+----------------------------+--------------------------------
//   item     | item_valid / item_stall    | emh_item_t: record or bin read
//   result   | result_valid / result_stall| emh_result_t: bin and six counts
//
// Each item: bank read at the accepting edge, then saturating write-back and result
// load in the execute state; one item at a time, as each bank does a single
// read-modify-write. After reset a clearing pass zeroes the banks over
// max(CHAMBER_BINS, TOTAL_BINS) addresses (4096 by default), with item_stall high throughout.
// A stalled result holds the next item in the execute state until the output register frees.
module event_multiplicity_histogrammer #(
	parameter int CHAMBER_BINS = emh_pkg::CHAMBER_BINS_DEF,
	parameter int TOTAL_BINS   = emh_pkg::TOTAL_BINS_DEF,
	parameter int COUNT_WIDTH  = emh_pkg::COUNT_WIDTH_DEF
) (
	input  logic                 clk,
	input  logic                 arst_n,
	input  logic                 item_valid,
	output logic                 item_stall,
	input  emh_pkg::emh_item_t   item,
	output logic                 result_valid,
	input  logic                 result_stall,
	output emh_pkg::emh_result_t result
);
	import emh_pkg::*;

	localparam int SWEEP_DEPTH = (CHAMBER_BINS > TOTAL_BINS) ? CHAMBER_BINS : TOTAL_BINS;
	localparam int SW = $clog2(SWEEP_DEPTH);

	emh_cmd_t      cmd;
	logic [SW-1:0] sweep;

	emh_ctrl #(
		.SWEEP_DEPTH(SWEEP_DEPTH)
	) u_ctrl (
		.clk          (clk),
		.arst_n       (arst_n),
		.item_valid   (item_valid),
		.item_stall   (item_stall),
		.result_valid (result_valid),
		.result_stall (result_stall),
		.cmd          (cmd),
		.sweep        (sweep)
	);

	emh_datapath #(
		.CHAMBER_BINS (CHAMBER_BINS),
		.TOTAL_BINS   (TOTAL_BINS),
		.COUNT_WIDTH  (COUNT_WIDTH),
		.SWEEP_DEPTH  (SWEEP_DEPTH)
	) u_datapath (
		.clk    (clk),
		.arst_n (arst_n),
		.cmd    (cmd),
		.sweep  (sweep),
		.item   (item),
		.result (result)
	);

endmodule

// ===== hw/rtl/emh_checker.sv =====
// Port-level checks of the histogrammer, bound to the top level.
// Depends on emh_pkg and assert_macros.svh.
`include "assert_macros.svh"

module emh_checker (
	input logic                 clk,
	input logic                 arst_n,
	input logic                 item_valid,
	input logic                 item_stall,
	input logic                 result_valid,
	input logic                 result_stall,
	input emh_pkg::emh_result_t result
);
	import emh_pkg::*;

	// one item in flight: the beat after an accept is always held off
	`EMH_ASSERT_NEXT(a_one_in_flight, clk, arst_n, item_valid && !item_stall, item_stall)

	// a fresh result only appears while an item is being worked on
	`EMH_ASSERT_SAME(a_result_from_item, clk, arst_n, $rose(result_valid), $past(item_stall))

	`EMH_ASSERT_NEXT(a_result_held, clk, arst_n, result_valid && result_stall, result_valid)

	`EMH_ASSERT_NEXT(a_result_stable, clk, arst_n, result_valid && result_stall, $stable(result))

endmodule

bind event_multiplicity_histogrammer emh_checker u_emh_checker (.*);
